[rtl/core/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants for the contour segment extractor.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int SAMPLE_W = 16;
    localparam int Q_W      = 17;
    localparam int COORD_W  = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // grid size limit and coordinate fraction bits
    localparam int GRID_MAX  = 256;
    localparam int FRAC_BITS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ISOVALUE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_UP     = 2'd2;

    // corner code bits
    localparam logic [3:0] CORNER_BL = 4'h1;
    localparam logic [3:0] CORNER_BR = 4'h2;
    localparam logic [3:0] CORNER_TL = 4'h4;
    localparam logic [3:0] CORNER_TR = 4'h8;

    // crossing point selectors
    typedef enum logic [1:0] {
        PT_L = 2'd0,
        PT_B = 2'd1,
        PT_T = 2'd2,
        PT_R = 2'd3
    } pt_sel_t;

    // back part sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT1,
        BK_EMIT2
    } bk_state_t;

    // one cell handed from front to back
    typedef struct packed {
        logic [Q_W-1:0] bl;
        logic [Q_W-1:0] br;
        logic [Q_W-1:0] tl;
        logic [Q_W-1:0] tr;
        logic [7:0]     cc;
        logic [7:0]     cr;
    } cell_t;

    // segment end point pair for a code; ambiguous codes handled apart
    function automatic logic [3:0] seg_pair(input logic [3:0] code);
        logic [3:0] r;
        case (code)
            4'd1, 4'd14: r = {PT_L, PT_B};
            4'd2, 4'd13: r = {PT_B, PT_R};
            4'd3, 4'd12: r = {PT_L, PT_R};
            4'd4, 4'd11: r = {PT_L, PT_T};
            4'd5, 4'd10: r = {PT_B, PT_T};
            4'd7, 4'd8:  r = {PT_T, PT_R};
            default:     r = {PT_L, PT_R};
        endcase
        return r;
    endfunction

endpackage

[rtl/core/cse_ram.sv]
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/cse_front.sv]
// ----------------------------------------------------------------------------
// cse_front
// Accepts samples, keeps the previous row in RAM, forms complete cells.
// Per sample: read both row entries, then write back and issue; full stays high in between.
// ----------------------------------------------------------------------------
module cse_front
    import cse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  push,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  full,
    output logic                  cell_valid,
    output cell_t                 cell_data,
    input  logic                  cell_ready
);

    localparam int AW = $clog2(GRID_MAX + 1);
    localparam int GW = $clog2(GRID_MAX + 1);

    logic [SAMPLE_W-1:0] iso_reg;
    logic [8:0]          across_reg, up_reg;
    logic [GW-1:0]       col_reg, row_reg;
    logic [Q_W-1:0]      left_reg, q_reg;
    logic [1:0]          ph_reg;     // 0 idle, 1 first read, 2 second read
    logic [Q_W-1:0]      bl_reg;
    logic                have_reg;
    cell_t               cell_reg;
    logic [GW-1:0]       ncols, nrows, col_c;
    logic                rd_en_we;
    logic [AW-1:0]       raddr, waddr;
    logic [Q_W-1:0]      rdata, wdata;
    logic                we;
    logic                cfg_hit;

    assign cfg_hit = cfg_we && (cfg_idx == REG_ISOVALUE || cfg_idx == REG_CELLS_ACROSS
                                || cfg_idx == REG_CELLS_UP);

    // clamp grid sizes
    always_comb
    begin
        if (across_reg == '0)
            ncols = GW'(1);
        else if ({1'b0, across_reg} > 10'(GRID_MAX))
            ncols = GW'(GRID_MAX);
        else
            ncols = GW'(across_reg);
        if (up_reg == '0)
            nrows = GW'(1);
        else if ({1'b0, up_reg} > 10'(GRID_MAX))
            nrows = GW'(GRID_MAX);
        else
            nrows = GW'(up_reg);
        col_c = (col_reg > ncols) ? ncols : col_reg;
    end

    assign full = (ph_reg != 2'd0) || have_reg;

    // row RAM addressing: phase 0 reads col-1, phases 1 and 2 read col
    always_comb
    begin
        raddr = (ph_reg == 2'd0) ? AW'(col_c - ((col_c != '0) ? GW'(1) : GW'(0)))
                                 : AW'(col_c);
        we    = 1'b0;
        waddr = AW'(col_c);
        wdata = q_reg;
        if (ph_reg == 2'd2 && col_c == ncols)
            we = 1'b1;
    end

    // col-1 write of left value happens at accept
    logic          we_a;
    assign rd_en_we = push && !full;
    assign we_a = rd_en_we && (col_c != '0);

    cse_ram #(.WIDTH(Q_W), .DEPTH(GRID_MAX + 1)) u_row (
        .clk   (clk),
        .we    (we_a | we),
        .waddr (we_a ? AW'(col_c - GW'(1)) : waddr),
        .wdata (we_a ? left_reg : wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // read col-1 is issued in the accept cycle (before the write there lands,
    // so the old row value is seen)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg    <= '0;
            across_reg <= 9'd12;
            up_reg     <= 9'd12;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            ph_reg     <= 2'd0;
            have_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
                case (cfg_idx)
                    REG_ISOVALUE:     iso_reg    <= cfg_data;
                    REG_CELLS_ACROSS: across_reg <= cfg_data[8:0];
                    default:          up_reg     <= cfg_data[8:0];
                endcase
            end
            if (have_reg && cell_ready)
                have_reg <= 1'b0;
            case (ph_reg)
                2'd0:
                begin
                    if (rd_en_we)
                    begin
                        q_reg  <= Q_W'($signed(sample)) - Q_W'($signed(iso_reg));
                        ph_reg <= 2'd1;
                    end
                end
                2'd1:
                begin
                    bl_reg <= rdata;
                    ph_reg <= 2'd2;
                end
                default:
                begin
                    ph_reg   <= 2'd0;
                    left_reg <= q_reg;
                    if (col_c != '0 && row_reg != '0)
                    begin
                        have_reg      <= 1'b1;
                        cell_reg.bl   <= bl_reg;
                        cell_reg.br   <= rdata;
                        cell_reg.tl   <= left_reg;
                        cell_reg.tr   <= q_reg;
                        cell_reg.cc   <= 8'(col_c - GW'(1));
                        cell_reg.cr   <= 8'(row_reg - GW'(1));
                    end
                    if (col_c >= ncols)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_reg >= nrows) ? '0 : row_reg + GW'(1);
                    end
                    else
                    begin
                        col_reg <= col_c + GW'(1);
                    end
                end
            endcase
        end
    end

    assign cell_valid = have_reg;
    assign cell_data  = cell_reg;

endmodule

[rtl/core/cse_back.sv]
// ----------------------------------------------------------------------------
// cse_back
// Classifies a cell, runs four crossing divisions bit-serially in parallel,
// then emits its segments into a two-entry output queue.
// ----------------------------------------------------------------------------
module cse_back
    import cse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cell_valid,
    input  cell_t               cell_data,
    output logic                cell_ready,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          cell_col,
    output logic [7:0]          cell_row,
    output logic [COORD_W-1:0]  x_start,
    output logic [COORD_W-1:0]  y_start,
    output logic [COORD_W-1:0]  x_end,
    output logic [COORD_W-1:0]  y_end,
    output logic                last_of_cell
);

    localparam int MW = Q_W + 1;             // magnitude width
    localparam int NW = MW + FRAC_BITS + 1;  // numerator / quotient width
    localparam int CW = $clog2(NW + 1);
    localparam int SEGW = 8 + 8 + 4 * COORD_W + 1;

    bk_state_t         st_reg, st_next;
    cell_t             c_reg;
    logic [3:0]        code_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NW-1:0]     num_reg [4];
    logic [MW:0]       den_reg [4];
    logic [NW-1:0]     quo_reg [4];
    logic [MW:0]       rem_reg [4];
    logic [3:0]        has_reg;
    logic [SEGW-1:0]   q_mem [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_q_reg;
    logic              push_seg;
    logic [SEGW-1:0]   seg_w;

    // edge pairs: 0 L(bl,tl) 1 B(bl,br) 2 T(tl,tr) 3 R(br,tr)
    function automatic logic [MW-1:0] mag(input logic [Q_W-1:0] v);
        return v[Q_W-1] ? MW'(-$signed({v[Q_W-1], v})) : MW'(v);
    endfunction

    logic [Q_W-1:0] ea [4], eb [4];
    always_comb
    begin
        ea[0] = cell_data.bl; eb[0] = cell_data.tl;
        ea[1] = cell_data.bl; eb[1] = cell_data.br;
        ea[2] = cell_data.tl; eb[2] = cell_data.tr;
        ea[3] = cell_data.br; eb[3] = cell_data.tr;
    end

    assign cell_ready = (st_reg == BK_IDLE);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:  if (cell_valid) st_next = BK_DIV;
            BK_DIV:   if (cnt_reg == CW'(NW)) st_next = BK_EMIT1;
            BK_EMIT1:
            begin
                if (cnt_q_reg != 2'd2 || (code_reg == 4'd0 || code_reg == 4'd15))
                begin
                    if (code_reg == 4'd6 || code_reg == 4'd9)
                        st_next = BK_EMIT2;
                    else
                        st_next = BK_IDLE;
                end
            end
            BK_EMIT2: if (cnt_q_reg != 2'd2) st_next = BK_IDLE;
            default:  st_next = BK_IDLE;
        endcase
    end

    // crossing points
    logic [COORD_W-1:0] bx, by, one_c;
    logic [COORD_W-1:0] px [4], py [4];
    always_comb
    begin
        bx    = COORD_W'({c_reg.cc, FRAC_BITS'(0)});
        by    = COORD_W'({c_reg.cr, FRAC_BITS'(0)});
        one_c = COORD_W'(1) << FRAC_BITS;
        px[0] = bx;                               py[0] = by + COORD_W'(quo_reg[0]);
        px[1] = bx + COORD_W'(quo_reg[1]);        py[1] = by;
        px[2] = bx + COORD_W'(quo_reg[2]);        py[2] = by + one_c;
        px[3] = bx + one_c;                       py[3] = by + COORD_W'(quo_reg[3]);
    end

    // segment builder
    logic [1:0] sa, sb;
    logic       lastb;
    logic [3:0] pr;
    always_comb
    begin
        pr    = seg_pair(code_reg);
        sa    = pr[3:2];
        sb    = pr[1:0];
        lastb = 1'b1;
        if (code_reg == 4'd6 || code_reg == 4'd9)
        begin
            if (st_reg == BK_EMIT1)
            begin
                sa = PT_L;
                sb = (px[1] > px[2]) ? PT_T : PT_B;
                lastb = 1'b0;
            end
            else
            begin
                sa = (px[1] > px[2]) ? PT_B : PT_T;
                sb = PT_R;
            end
        end
        seg_w = {c_reg.cc, c_reg.cr, px[sa], py[sa], px[sb], py[sb], lastb};
        push_seg = ((st_reg == BK_EMIT1 && code_reg != 4'd0 && code_reg != 4'd15)
                    || st_reg == BK_EMIT2) && cnt_q_reg != 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BK_IDLE;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            cnt_q_reg <= 2'd0;
        end
        else
        begin
            st_reg <= st_next;
            if (push_seg)
                wp_reg <= ~wp_reg;
            if (pop && !empty)
                rp_reg <= ~rp_reg;
            cnt_q_reg <= cnt_q_reg + 2'(push_seg) - 2'(pop && !empty);
        end
    end

    // payload: capture, restoring division one bit per cycle
    always_ff @(posedge clk)
    begin
        if (push_seg)
            q_mem[wp_reg] <= seg_w;
        if (st_reg == BK_IDLE && cell_valid)
        begin
            c_reg    <= cell_data;
            code_reg <= (cell_data.bl[Q_W-1] ? 4'h0 : CORNER_BL)
                      | (cell_data.br[Q_W-1] ? 4'h0 : CORNER_BR)
                      | (cell_data.tl[Q_W-1] ? 4'h0 : CORNER_TL)
                      | (cell_data.tr[Q_W-1] ? 4'h0 : CORNER_TR);
            cnt_reg  <= '0;
            for (int i = 0; i < 4; i++)
            begin
                has_reg[i] <= ea[i][Q_W-1] != eb[i][Q_W-1];
                // numerator |a|*2^F + d/2, denominator |a|+|b|
                num_reg[i] <= (NW'(mag(ea[i])) << FRAC_BITS)
                              + NW'(({1'b0, mag(ea[i])} + {1'b0, mag(eb[i])}) >> 1);
                den_reg[i] <= {1'b0, mag(ea[i])} + {1'b0, mag(eb[i])};
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
        end
        else if (st_reg == BK_DIV && cnt_reg != CW'(NW))
        begin
            cnt_reg <= cnt_reg + CW'(1);
            for (int i = 0; i < 4; i++)
            begin
                logic [MW+1:0] t;
                t = {rem_reg[i], num_reg[i][NW-1]};
                num_reg[i] <= num_reg[i] << 1;
                if (t >= {1'b0, den_reg[i]})
                begin
                    rem_reg[i] <= (MW+1)'(t - {1'b0, den_reg[i]});
                    quo_reg[i] <= {quo_reg[i][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= (MW+1)'(t);
                    quo_reg[i] <= {quo_reg[i][NW-2:0], 1'b0};
                end
            end
        end
        else if (st_reg == BK_DIV)
        begin
            for (int i = 0; i < 4; i++)
                if (!has_reg[i])
                    quo_reg[i] <= '0;
        end
    end

    assign empty = (cnt_q_reg == 2'd0);
    assign {cell_col, cell_row, x_start, y_start, x_end, y_end, last_of_cell} = q_mem[rp_reg];

endmodule

[rtl/core/contour_segment_extractor_core.sv]
// ----------------------------------------------------------------------------
// contour_segment_extractor_core
// Marching squares segment extractor over a raster-order node stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive sample and push while full is low; one node per item,
//   bottom node row first, left to right.
//   Output queue: while empty is low a segment is on the result ports; pop
//   takes it. A cell gives 0, 1 or 2 segments, last_of_cell on the final one.
//   Config: cfg_we/cfg_idx/cfg_data write isovalue, cells_across, cells_up;
//   each such write restarts the frame at node (0,0). Write only while idle.
// Flow:
//   The front takes a sample, does two row RAM reads, then write-back, and
//   takes no new sample until then. The back takes a cell when idle, runs
//   its bit-serial crossing divider, then emits one segment per cycle while
//   the output queue has room; a cell without segments still passes through
//   the emit state. A one-cell hand-off register between front and back
//   decouples them.
// Reset: clears position, registers to isovalue 0 and a 12 x 12 grid, and
//   empties the output queue. Row RAM needs no clearing.
// Stall: when the receiver stops popping, the two-entry output queue fills,
//   the back waits, then the front, then full stays high.
// ----------------------------------------------------------------------------
module contour_segment_extractor_core
    import cse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [SAMPLE_W-1:0]  sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           cell_col,
    output logic [7:0]           cell_row,
    output logic [COORD_W-1:0]   x_start,
    output logic [COORD_W-1:0]   y_start,
    output logic [COORD_W-1:0]   x_end,
    output logic [COORD_W-1:0]   y_end,
    output logic                 last_of_cell
);

    logic  cell_valid, cell_ready;
    cell_t cell_data;

    cse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .push       (push),
        .sample     (sample),
        .full       (full),
        .cell_valid (cell_valid),
        .cell_data  (cell_data),
        .cell_ready (cell_ready)
    );

    cse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_data    (cell_data),
        .cell_ready   (cell_ready),
        .empty        (empty),
        .pop          (pop),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .last_of_cell (last_of_cell)
    );

endmodule

[rtl/core/cse_checker.sv]
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks for the contour segment extractor.
// ----------------------------------------------------------------------------
module cse_checker
    import cse_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [7:0]         cell_col,
    input logic [COORD_W-1:0] x_start,
    input logic               last_of_cell
);

    // front is busy right after taking an item
    a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("accepted item did not block the input");

    // a waiting result holds while not popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(x_start) && $stable(cell_col))
        else $error("waiting result changed");

    // first segment of an ambiguous pair is followed by its partner
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_of_cell |=> !empty)
        else $error("missing second segment of cell");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result present after reset");

endmodule

bind contour_segment_extractor_core cse_checker u_cse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .cell_col     (cell_col),
    .x_start      (x_start),
    .last_of_cell (last_of_cell)
);

[dv/contour_segment_extractor_core_chk.sv]
// ----------------------------------------------------------------------------
// contour_segment_extractor_core_chk
// Watches the config port and both queues of the segment extractor, predicts
// the segments of every accepted node and compares them as they are popped.
// ----------------------------------------------------------------------------
module contour_segment_extractor_core_chk
    import cse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [7:0]           cell_col,
    input  logic [7:0]           cell_row,
    input  logic [COORD_W-1:0]   x_start,
    input  logic [COORD_W-1:0]   y_start,
    input  logic [COORD_W-1:0]   x_end,
    input  logic [COORD_W-1:0]   y_end,
    input  logic                 last_of_cell,
    output int                   pending,
    output int                   fails
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_LIM = 256;
    localparam int FRAC     = 8;
    localparam logic [3:0] AMBIG_DIAG_A = CORNER_BR | CORNER_TL;
    localparam logic [3:0] AMBIG_DIAG_B = CORNER_BL | CORNER_TR;

    typedef struct packed {
        logic [7:0]         col;
        logic [7:0]         row;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic               last;
    } segment_t;

    segment_t expected_segs[$];

    // predicted block state
    logic [15:0]   iso_reg;
    logic [8:0]    across_reg;
    logic [8:0]    up_reg;
    longint        prev_row_q[0:GRID_LIM];
    longint        left_q;
    int            at_col;
    int            at_row;

    assign pending = expected_segs.size();

    function automatic int eff_size(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > GRID_LIM) return GRID_LIM;
        return int'(v);
    endfunction

    // crossing offset from node a toward node b, rounded half up
    function automatic longint cross_off(input longint a, input longint b);
        longint ua, d;
        if ((a >= 0) == (b >= 0)) return 0;
        ua = (a < 0) ? -a : a;
        d  = ua + ((b < 0) ? -b : b);
        return ((ua << FRAC) + d / 2) / d;
    endfunction

    function automatic segment_t make_seg(input int cc, input int cr,
                                          input longint px, input longint py,
                                          input longint ex, input longint ey,
                                          input logic last);
        segment_t s;
        s.col  = cc[7:0];
        s.row  = cr[7:0];
        s.xs   = px[COORD_W-1:0];
        s.ys   = py[COORD_W-1:0];
        s.xe   = ex[COORD_W-1:0];
        s.ye   = ey[COORD_W-1:0];
        s.last = last;
        return s;
    endfunction

    // append one predicted segment at the tail
    task automatic queue_seg(input segment_t s);
        expected_segs.insert(expected_segs.size(), s);
    endtask

    // advance the node position and queue the segments this node completes
    task automatic predict_node(input logic [15:0] raw);
        longint  q, bl, br, tl, tr;
        longint  px[4], py[4];
        logic [3:0] code;
        int      ncols, nrows, col, row, cc, cr;
        pt_sel_t a, b, first, second;
        q     = longint'($signed(raw)) - longint'($signed(iso_reg));
        ncols = eff_size(across_reg);
        nrows = eff_size(up_reg);
        col   = (at_col > ncols) ? ncols : at_col;
        row   = at_row;
        if (col > 0 && row > 0) begin
            bl = prev_row_q[col-1];
            br = prev_row_q[col];
            tl = left_q;
            tr = q;
            code = ((bl >= 0) ? CORNER_BL : 4'h0) | ((br >= 0) ? CORNER_BR : 4'h0) |
                   ((tl >= 0) ? CORNER_TL : 4'h0) | ((tr >= 0) ? CORNER_TR : 4'h0);
            cc = col - 1;
            cr = row - 1;
            px[PT_L] = longint'(cc) << FRAC;
            py[PT_L] = (longint'(cr) << FRAC) + cross_off(bl, tl);
            px[PT_B] = (longint'(cc) << FRAC) + cross_off(bl, br);
            py[PT_B] = longint'(cr) << FRAC;
            px[PT_T] = (longint'(cc) << FRAC) + cross_off(tl, tr);
            py[PT_T] = (longint'(cr) << FRAC) + (1 << FRAC);
            px[PT_R] = (longint'(cc) << FRAC) + (1 << FRAC);
            py[PT_R] = (longint'(cr) << FRAC) + cross_off(br, tr);
            if (code == AMBIG_DIAG_A || code == AMBIG_DIAG_B) begin
                first  = PT_B;
                second = PT_T;
                if (px[PT_B] > px[PT_T]) begin
                    first  = PT_T;
                    second = PT_B;
                end
                queue_seg(make_seg(cc, cr, px[PT_L], py[PT_L],
                                   px[first], py[first], 1'b0));
                queue_seg(make_seg(cc, cr, px[second], py[second],
                                   px[PT_R], py[PT_R], 1'b1));
            end else begin
                a = PT_L;
                b = PT_L;
                case (code)
                    4'd1, 4'd14: begin a = PT_L; b = PT_B; end
                    4'd2, 4'd13: begin a = PT_B; b = PT_R; end
                    4'd3, 4'd12: begin a = PT_L; b = PT_R; end
                    4'd4, 4'd11: begin a = PT_L; b = PT_T; end
                    4'd5, 4'd10: begin a = PT_B; b = PT_T; end
                    4'd7, 4'd8:  begin a = PT_T; b = PT_R; end
                    default:     ;
                endcase
                if (a != b)
                    queue_seg(make_seg(cc, cr, px[a], py[a],
                                       px[b], py[b], 1'b1));
            end
        end
        // row memory and position update
        if (col > 0) prev_row_q[col-1] = left_q;
        if (col == ncols) prev_row_q[col] = q;
        left_q = q;
        if (col >= ncols) begin
            at_col = 0;
            at_row = (row >= nrows) ? 0 : row + 1;
        end else begin
            at_col = col + 1;
        end
    endtask

    task automatic check_field(input string name, input longint exp_v,
                               input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    initial begin
        fails      = 0;
        iso_reg    = '0;
        across_reg = 9'd12;
        up_reg     = 9'd12;
        left_q     = 0;
        at_col     = 0;
        at_row     = 0;
        foreach (prev_row_q[i]) prev_row_q[i] = 0;
    end

    always @(posedge clk) begin
        segment_t e;
        if (rst_n) begin
            // popped segment against the oldest prediction
            if (pop && !empty) begin
                if (expected_segs.size() == 0) begin
                    $error("segment popped with none expected");
                    fails++;
                end else begin
                    e = expected_segs.pop_front();
                    check_field("cell_col", e.col, cell_col);
                    check_field("cell_row", e.row, cell_row);
                    check_field("x_start", e.xs, x_start);
                    check_field("y_start", e.ys, y_start);
                    check_field("x_end", e.xe, x_end);
                    check_field("y_end", e.ye, y_end);
                    check_field("last_of_cell", e.last, last_of_cell);
                end
            end
            // register writes restart the frame
            if (cfg_we) begin
                case (cfg_idx)
                    REG_ISOVALUE:     begin iso_reg = cfg_data;         at_col = 0; at_row = 0; end
                    REG_CELLS_ACROSS: begin across_reg = cfg_data[8:0]; at_col = 0; at_row = 0; end
                    REG_CELLS_UP:     begin up_reg = cfg_data[8:0];     at_col = 0; at_row = 0; end
                    default:          ;
                endcase
            end
            if (push && !full) predict_node(sample);
        end
    end

endmodule

[dv/contour_segment_extractor_core_tb.sv]
// ----------------------------------------------------------------------------
// contour_segment_extractor_core_tb
// Drives node streams over many grid settings through the extractor, with
// random gaps and stalls on both queues; the checker predicts every segment.
// ----------------------------------------------------------------------------
module contour_segment_extractor_core_tb;
    import cse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int NODE_TARGET = 850;
    localparam int DRAIN_WAIT  = 120;
    localparam int LONG_HOLD   = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [SAMPLE_W-1:0]  sample;
    logic                 empty;
    logic                 pop;
    logic [7:0]           cell_col;
    logic [7:0]           cell_row;
    logic [COORD_W-1:0]   x_start;
    logic [COORD_W-1:0]   y_start;
    logic [COORD_W-1:0]   x_end;
    logic [COORD_W-1:0]   y_end;
    logic                 last_of_cell;
    int                   pending;
    int                   fails;

    bit                   hold_pop;
    bit                   no_gaps;
    int                   nodes_sent;
    int                   iso_now;

    contour_segment_extractor_core u_top (.*);

    contour_segment_extractor_core_chk u_chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // --- sender side ---
    task automatic push_node(input int value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push   <= 1'b1;
        sample <= value[15:0];
        do @(posedge clk); while (full);
        @(negedge clk);
        nodes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[15:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // block drained: all segments popped, then room for a cell still in the divider
    task automatic wait_drained;
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_grid(input int iso, input int across, input int up);
        write_reg(REG_ISOVALUE, iso);
        write_reg(REG_CELLS_ACROSS, across | ($urandom_range(0, 127) << 9));
        write_reg(REG_CELLS_UP, up | ($urandom_range(0, 127) << 9));
        iso_now = iso;
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // mostly near the level so crossings are common
    function automatic int rand_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return clamp16(iso_now + $urandom_range(0, 1200) - 600);
        if (pick < 85) return int'($signed(16'($urandom())));
        case ($urandom_range(0, 3))
            0:       return 32767;
            1:       return -32768;
            2:       return clamp16(iso_now);
            default: return clamp16(iso_now - 1);
        endcase
    endfunction

    function automatic int rand_size();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // --- receiver side ---
    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pop)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_pop = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // --- stimulus ---
    initial
    begin
        int directed_nodes[24];
        int phase, across, up, nodes, iso;
        directed_nodes = '{32767, -32768, 0, -1,
                           -1, 0, 32767, -32768,
                           1, -1, 1, -1,
                           -1, 1, -1, 1,
                           -32768, 32767, -32768, 32767,
                           100, -300, 5, -7};
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        push       = 1'b0;
        sample     = '0;
        hold_pop   = 1'b0;
        no_gaps    = 1'b0;
        nodes_sent = 0;
        iso_now    = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, both ambiguous codes, zero classified as inside
        set_grid(0, 3, 5);
        foreach (directed_nodes[i]) push_node(directed_nodes[i]);
        wait_drained();
        // extreme level, wrap of a single-cell frame, ignored spare index
        set_grid(-32768, 1, 1);
        write_reg(REG_SPARE, 32'h0000_FFFF);
        repeat (10) push_node(rand_sample());
        wait_drained();
        set_grid(32767, 0, 0);
        repeat (10) push_node(rand_sample());

        phase = 0;
        while (nodes_sent < NODE_TARGET)
        begin
            wait_drained();
            iso    = (phase % 11 == 3) ? -32768 : (phase % 11 == 7) ? 32767 :
                     int'($urandom_range(0, 6000)) - 3000;
            across = rand_size();
            up     = rand_size();
            nodes  = $urandom_range(4, 50);
            if (phase == 2)
            begin
                // receiver stalls long while nodes keep coming
                across = 8;
                up     = 8;
                nodes  = 60;
                hold_pop = 1'b1;
            end
            else if (phase == 4 || phase == 9)
            begin
                // widest rows, oversize value clamps
                across = (phase == 4) ? 256 : 511;
                up     = 1 + (phase == 9 ? 300 : 0);
                nodes  = 300;
            end
            no_gaps = (phase % 5 == 1);
            set_grid(iso, across, up);
            if (phase % 6 == 5) write_reg(REG_SPARE, $urandom());
            repeat (nodes) push_node(rand_sample());
            phase++;
        end

        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/cse_pkg.sv
rtl/core/cse_ram.sv
rtl/core/cse_front.sv
rtl/core/cse_back.sv
rtl/core/contour_segment_extractor_core.sv
rtl/core/cse_checker.sv
dv/contour_segment_extractor_core_chk.sv
dv/contour_segment_extractor_core_tb.sv
